FILE: rtl/skqt_pkg.sv
// Package for the sorted key/quantity table: sizes, operation and status codes,
// sequencer states and the structs passed between the table's modules.
// No dependencies.
package skqt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN0,
    S_SCAN,
    S_SHIFT,
    S_INS_WR,
    S_UPD,
    S_LIST0,
    S_LIST
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_quantity;
    logic               last;
  } out_item_t;

  // request to the entry store: one registered read and one write per cycle
  typedef struct packed {
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [31:0]      wkey;
    logic signed [31:0]      wqty;
  } store_req_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic               lt;
    logic               eq;
    logic signed [31:0] sat;
  } alu_res_t;

endpackage

FILE: rtl/sorted_key_quantity_table_unit.sv
// Top level of the sorted key/quantity table: sequencer, entry count and
// result register. Depends on skqt_pkg, skqt_store and skqt_alu.
//
// A command is taken when start is high and busy low; busy stays high until
// the command's work is done. The scan for the key stops at the insertion
// point, and an insert then moves the entries above it up one place per
// cycle through the single write port, so scan and move together pass over
// the table once. A list gives one result per cycle.
// Results appear for one cycle on out_item with out_valid high and cannot be
// held off; out_item.last marks the final result of a command. The table
// holds up to 64 entries and needs no clearing after reset.
module sorted_key_quantity_table_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  skqt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output skqt_pkg::out_item_t  out_item
);

  localparam int IW = skqt_pkg::IDX_W;
  localparam int CW = skqt_pkg::CNT_W;

  skqt_pkg::state_t    state_r, state_nxt;
  skqt_pkg::op_t       op_r, op_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic signed [31:0]  amt_r, amt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  skqt_pkg::out_item_t out_r, out_nxt;

  skqt_pkg::store_req_t sreq;
  skqt_pkg::alu_req_t   areq;
  skqt_pkg::alu_res_t   ares;
  logic signed [31:0]   rkey;
  logic signed [31:0]   rqty;

  logic          at_end;
  logic          hit;
  logic [CW-1:0] j_dec;

  skqt_store u_store (
    .clk  (clk),
    .req  (sreq),
    .rkey (rkey),
    .rqty (rqty)
  );

  skqt_alu u_alu (
    .req (areq),
    .res (ares)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skqt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    amt_r <= amt_nxt;
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
    out_r <= out_nxt;
  end

  assign at_end = (idx_r == count_r);
  assign hit    = !at_end && ares.eq;
  assign j_dec  = j_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    sreq          = '0;
    areq.a        = rkey;
    areq.b        = key_r;
    areq.sub      = 1'b1;

    case (state_r)
      skqt_pkg::S_IDLE: begin
        if (start) begin
          op_nxt  = in_item.operation;
          key_nxt = in_item.part_key;
          amt_nxt = in_item.amount;
          if (in_item.operation == skqt_pkg::OP_LIST) begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{skqt_pkg::ST_EMPTY, 32'sd0, 32'sd0, 1'b1};
            end else begin
              state_nxt = skqt_pkg::S_LIST0;
            end
          end else begin
            state_nxt = skqt_pkg::S_SCAN0;
          end
        end
      end

      skqt_pkg::S_SCAN0: begin
        sreq.re   = 1'b1;
        sreq.raddr = '0;
        idx_nxt   = '0;
        state_nxt = skqt_pkg::S_SCAN;
      end

      // read data holds entry idx_r; the next entry is fetched speculatively
      skqt_pkg::S_SCAN: begin
        if (!at_end && ares.lt) begin
          idx_nxt    = idx_r + CW'(1);
          sreq.re    = 1'b1;
          sreq.raddr = idx_nxt[IW-1:0];
        end else begin
          state_nxt = skqt_pkg::S_IDLE;
          case (op_r)
            skqt_pkg::OP_INSERT: begin
              if (hit) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{skqt_pkg::ST_EXISTS, key_r, rqty, 1'b1};
              end else if (count_r == CW'(skqt_pkg::TABLE_DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{skqt_pkg::ST_FULL, key_r, 32'sd0, 1'b1};
              end else if (at_end) begin
                state_nxt = skqt_pkg::S_INS_WR;
              end else begin
                j_nxt      = count_r;
                sreq.re    = 1'b1;
                sreq.raddr = IW'(count_r - CW'(1));
                state_nxt  = skqt_pkg::S_SHIFT;
              end
            end
            skqt_pkg::OP_SEARCH: begin
              out_valid_nxt = 1'b1;
              if (hit) begin
                out_nxt = '{skqt_pkg::ST_OK, key_r, rqty, 1'b1};
              end else begin
                out_nxt = '{skqt_pkg::ST_NOT_FOUND, key_r, 32'sd0, 1'b1};
              end
            end
            skqt_pkg::OP_UPDATE: begin
              if (hit) begin
                state_nxt = skqt_pkg::S_UPD;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{skqt_pkg::ST_NOT_FOUND, key_r, 32'sd0, 1'b1};
              end
            end
            default: begin
            end
          endcase
        end
      end

      // move entry j-1 up to j, fetching j-2 in the same cycle
      skqt_pkg::S_SHIFT: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_r[IW-1:0];
        sreq.wkey  = rkey;
        sreq.wqty  = rqty;
        j_nxt      = j_dec;
        if (j_dec == idx_r) begin
          state_nxt = skqt_pkg::S_INS_WR;
        end else begin
          sreq.re    = 1'b1;
          sreq.raddr = IW'(j_r - CW'(2));
        end
      end

      skqt_pkg::S_INS_WR: begin
        sreq.we       = 1'b1;
        sreq.waddr    = idx_r[IW-1:0];
        sreq.wkey     = key_r;
        sreq.wqty     = amt_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_nxt       = '{skqt_pkg::ST_OK, key_r, amt_r, 1'b1};
        state_nxt     = skqt_pkg::S_IDLE;
      end

      skqt_pkg::S_UPD: begin
        areq.a        = rqty;
        areq.b        = amt_r;
        areq.sub      = 1'b0;
        sreq.we       = 1'b1;
        sreq.waddr    = idx_r[IW-1:0];
        sreq.wkey     = key_r;
        sreq.wqty     = ares.sat;
        out_valid_nxt = 1'b1;
        out_nxt       = '{skqt_pkg::ST_OK, key_r, ares.sat, 1'b1};
        state_nxt     = skqt_pkg::S_IDLE;
      end

      skqt_pkg::S_LIST0: begin
        sreq.re    = 1'b1;
        sreq.raddr = '0;
        j_nxt      = '0;
        state_nxt  = skqt_pkg::S_LIST;
      end

      skqt_pkg::S_LIST: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{skqt_pkg::ST_OK, rkey, rqty,
                          ((j_r + CW'(1)) == count_r)};
        if ((j_r + CW'(1)) == count_r) begin
          state_nxt = skqt_pkg::S_IDLE;
        end else begin
          j_nxt      = j_r + CW'(1);
          sreq.re    = 1'b1;
          sreq.raddr = j_nxt[IW-1:0];
        end
      end

      default: begin
        state_nxt = skqt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != skqt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(skqt_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    sreq.we |-> (state_r == skqt_pkg::S_SHIFT || state_r == skqt_pkg::S_INS_WR ||
                 state_r == skqt_pkg::S_UPD))
    else $error("store written outside shift, insert or update");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skqt_pkg::S_INS_WR) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not bump entry count");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != skqt_pkg::OP_LIST) |=> busy)
    else $error("accepted command did not go busy");

  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last && state_r != skqt_pkg::S_IDLE) |->
      (state_r == skqt_pkg::S_SCAN0 || state_r == skqt_pkg::S_LIST0))
    else $error("final beat seen while a command still in progress");

endmodule

FILE: rtl/skqt_store.sv
// Entry store of the sorted table: key and quantity memories with one write
// port and one registered read port. Depends on skqt_pkg.
module skqt_store (
  input  logic                  clk,
  input  skqt_pkg::store_req_t  req,
  output logic signed [31:0]    rkey,
  output logic signed [31:0]    rqty
);

  logic signed [31:0] key_mem [skqt_pkg::TABLE_DEPTH];
  logic signed [31:0] qty_mem [skqt_pkg::TABLE_DEPTH];
  logic signed [31:0] rkey_r;
  logic signed [31:0] rqty_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.waddr] <= req.wkey;
      qty_mem[req.waddr] <= req.wqty;
    end
  end

  // read data holds until the next read, so a result can be used later
  always_ff @(posedge clk) begin
    if (req.re) begin
      rkey_r <= key_mem[req.raddr];
      rqty_r <= qty_mem[req.raddr];
    end
  end

  assign rkey = rkey_r;
  assign rqty = rqty_r;

endmodule

FILE: rtl/skqt_alu.sv
// Shared arithmetic unit: one 33-bit adder serves the key compare (subtract)
// and the saturating quantity update (add). Depends on skqt_pkg.
module skqt_alu (
  input  skqt_pkg::alu_req_t req,
  output skqt_pkg::alu_res_t res
);

  logic [32:0] a_ext;
  logic [32:0] b_ext;
  logic [32:0] sum;

  always_comb begin
    a_ext = {req.a[31], req.a};
    b_ext = req.sub ? ~{req.b[31], req.b} : {req.b[31], req.b};
    sum   = a_ext + b_ext + {32'd0, req.sub};
    res.lt = sum[32];
    res.eq = (req.a == req.b);
    // overflow when the two top bits disagree; clamp toward the sign
    if (sum[32] != sum[31]) begin
      res.sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res.sat = sum[31:0];
    end
  end

endmodule

FILE: sim/sorted_key_quantity_table_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_key_quantity_table_unit: directed then random table commands,
// each result beat checked against a shadow copy of the sorted table.
// Depends on skqt_pkg and the table RTL.
module sorted_key_quantity_table_unit_tb;

  localparam int RAND_CMDS    = 410;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 160;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    skqt_pkg::in_item_t item;
    int unsigned        gap;
  } cmd_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  skqt_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  skqt_pkg::out_item_t out_item;

  cmd_beat_t           cmd_queue[$];
  skqt_pkg::out_item_t expected_results[$];
  logic signed [31:0]  issued_keys[$];
  logic signed [31:0]  shadow_key [skqt_pkg::TABLE_DEPTH];
  logic signed [31:0]  shadow_qty [skqt_pkg::TABLE_DEPTH];
  int                  shadow_count = 0;
  int unsigned         idle_left = 0;
  int unsigned         calm_left = 0;
  int                  mismatches = 0;
  int                  stall_cycles = 0;

  sorted_key_quantity_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // Apply one command to the shadow table and queue the beats it should give.
  function automatic void predict_table_op(skqt_pkg::in_item_t cmd);
    int                  pos;
    longint              sum;
    skqt_pkg::out_item_t res;
    pos = 0;
    while (pos < shadow_count && shadow_key[pos] < cmd.part_key) pos++;
    res.status         = skqt_pkg::ST_OK;
    res.entry_key      = cmd.part_key;
    res.entry_quantity = '0;
    res.last           = 1'b1;
    case (cmd.operation)
      skqt_pkg::OP_INSERT: begin
        // duplicate check wins over the full check
        if (pos < shadow_count && shadow_key[pos] == cmd.part_key) begin
          res.status         = skqt_pkg::ST_EXISTS;
          res.entry_quantity = shadow_qty[pos];
        end else if (shadow_count == skqt_pkg::TABLE_DEPTH) begin
          res.status = skqt_pkg::ST_FULL;
        end else begin
          for (int j = shadow_count; j > pos; j--) begin
            shadow_key[j] = shadow_key[j-1];
            shadow_qty[j] = shadow_qty[j-1];
          end
          shadow_key[pos]    = cmd.part_key;
          shadow_qty[pos]    = cmd.amount;
          shadow_count++;
          res.entry_quantity = cmd.amount;
        end
        expected_results.push_back(res);
      end
      skqt_pkg::OP_SEARCH, skqt_pkg::OP_UPDATE: begin
        if (pos < shadow_count && shadow_key[pos] == cmd.part_key) begin
          if (cmd.operation == skqt_pkg::OP_UPDATE) begin
            sum = longint'(shadow_qty[pos]) + longint'(cmd.amount);
            if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
            if (sum < longint'(VAL_MIN)) sum = longint'(VAL_MIN);
            shadow_qty[pos] = sum[31:0];
          end
          res.entry_quantity = shadow_qty[pos];
        end else begin
          res.status = skqt_pkg::ST_NOT_FOUND;
        end
        expected_results.push_back(res);
      end
      default: begin
        if (shadow_count == 0) begin
          res.status    = skqt_pkg::ST_EMPTY;
          res.entry_key = '0;
          expected_results.push_back(res);
        end else begin
          for (int j = 0; j < shadow_count; j++) begin
            res.entry_key      = shadow_key[j];
            res.entry_quantity = shadow_qty[j];
            res.last           = (j == shadow_count - 1);
            expected_results.push_back(res);
          end
        end
      end
    endcase
  endfunction

  function automatic void push_cmd(skqt_pkg::op_t op, logic signed [31:0] key,
                                   logic signed [31:0] amt);
    cmd_beat_t b;
    b.item.operation = op;
    b.item.part_key  = key;
    b.item.amount    = amt;
    // occasional runs of back-to-back commands
    if (calm_left != 0) begin
      calm_left--;
      b.gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 20);
      b.gap = $urandom_range(0, 6);
    end
    if (op == skqt_pkg::OP_INSERT) issued_keys.push_back(key);
    cmd_queue.push_back(b);
  endfunction

  function automatic logic signed [31:0] special_value();
    case ($urandom_range(0, 6))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_MAX - 32'sd1;
      3:       return VAL_MIN + 32'sd1;
      4:       return 32'sd1;
      5:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Mostly keys already issued, some neighbours (likely misses), some random.
  function automatic logic signed [31:0] pick_key();
    int unsigned        r;
    logic signed [31:0] pick;
    r = $urandom_range(0, 99);
    if (issued_keys.size() == 0 || r >= 90) return $urandom;
    pick = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    if (r >= 75) return pick + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
    return pick;
  endfunction

  // Driver: one command beat held on in_item until start && !busy.
  always @(posedge clk) begin
    cmd_beat_t nxt;
    if (rst_n) begin
      if (start && !busy) predict_table_op(in_item);
      if (!start || !busy) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          nxt       = cmd_queue.pop_front();
          in_item   <= nxt.item;
          start     <= 1'b1;
          idle_left <= (cmd_queue.size() != 0) ? cmd_queue[0].gap : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat against the oldest expectation.
  always @(posedge clk) begin
    skqt_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: key %0d", out_item.entry_key);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.entry_key !== want.entry_key) begin
          $error("entry_key: expected %0d, got %0d", want.entry_key, out_item.entry_key);
          mismatches++;
        end
        if (out_item.entry_quantity !== want.entry_quantity) begin
          $error("entry_quantity: expected %0d, got %0d",
                 want.entry_quantity, out_item.entry_quantity);
          mismatches++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving in either direction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT - 1) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned        r;
    int unsigned        s;
    logic signed [31:0] key;
    logic signed [31:0] amt;

    // directed: empty table, extremes, duplicates, saturation both ways
    push_cmd(skqt_pkg::OP_LIST,   32'sd9, 32'sd9);
    push_cmd(skqt_pkg::OP_SEARCH, 32'sd5, 32'sd0);
    push_cmd(skqt_pkg::OP_UPDATE, 32'sd5, 32'sd3);
    push_cmd(skqt_pkg::OP_INSERT, VAL_MAX, VAL_MAX);
    push_cmd(skqt_pkg::OP_INSERT, VAL_MIN, VAL_MIN);
    push_cmd(skqt_pkg::OP_INSERT, 32'sd0, 32'sd0);
    push_cmd(skqt_pkg::OP_INSERT, 32'sd0, 32'sd77);
    push_cmd(skqt_pkg::OP_SEARCH, VAL_MIN, 32'sd0);
    push_cmd(skqt_pkg::OP_SEARCH, VAL_MAX, 32'sd0);
    push_cmd(skqt_pkg::OP_UPDATE, VAL_MAX, 32'sd1);
    push_cmd(skqt_pkg::OP_UPDATE, VAL_MIN, -32'sd1);
    push_cmd(skqt_pkg::OP_UPDATE, 32'sd0, VAL_MIN);
    push_cmd(skqt_pkg::OP_UPDATE, 32'sd0, VAL_MIN);
    push_cmd(skqt_pkg::OP_UPDATE, 32'sd0, VAL_MAX);
    push_cmd(skqt_pkg::OP_INSERT, -32'sd1, 32'sd1234);
    push_cmd(skqt_pkg::OP_INSERT, 32'sd1, -32'sd5);
    push_cmd(skqt_pkg::OP_SEARCH, 32'sd1, 32'sd0);
    push_cmd(skqt_pkg::OP_SEARCH, 32'sd2, 32'sd0);
    push_cmd(skqt_pkg::OP_UPDATE, -32'sd1, VAL_MAX);
    push_cmd(skqt_pkg::OP_LIST,   VAL_MIN, VAL_MAX);
    push_cmd(skqt_pkg::OP_INSERT, VAL_MIN, 32'sd42);
    push_cmd(skqt_pkg::OP_SEARCH, VAL_MAX - 32'sd1, 32'sd0);

    // random: insert-heavy enough that the table fills and stays full
    for (int n = 0; n < RAND_CMDS; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < 40) begin
        if (s < 60)      key = $urandom;
        else if (s < 80) key = pick_key();
        else             key = special_value();
        amt = ($urandom_range(0, 4) == 0) ? special_value() : $urandom;
        push_cmd(skqt_pkg::OP_INSERT, key, amt);
      end else if (r < 62) begin
        push_cmd(skqt_pkg::OP_SEARCH, pick_key(), $urandom);
      end else if (r < 88) begin
        if (s < 40) begin
          amt = $urandom_range(0, 200);
          amt = amt - 32'sd100;
        end else if (s < 80) begin
          amt = $urandom;
        end else begin
          amt = special_value();
        end
        push_cmd(skqt_pkg::OP_UPDATE, pick_key(), amt);
      end else begin
        push_cmd(skqt_pkg::OP_LIST, $urandom, $urandom);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // sample on the falling edge, clear of the driver's updates
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/skqt_pkg.sv
rtl/skqt_store.sv
rtl/skqt_alu.sv
rtl/sorted_key_quantity_table_unit.sv
sim/sorted_key_quantity_table_unit_tb.sv
